[hw/rtl/ttce_pkg.sv]
// Shared types and constants for the text terminal character engine.
// Used by the front end, back end, top level and checker; depends on nothing else.
package ttce_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;
  localparam int CMDQ_DEPTH  = 2;
  localparam int RESQ_DEPTH  = 2;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_TAB       = 8'd9;
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  localparam logic [7:0] TEXT_COLOR_RST = 8'd10;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
  } out_item_t;

  typedef enum logic [2:0] {
    CMD_PUT,
    CMD_BS,
    CMD_TAB,
    CMD_NL,
    CMD_CR,
    CMD_CLEAR,
    CMD_READ,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;
    logic       read_ok;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SCROLL,
    BK_CLEAR
  } back_state_t;

endpackage

[hw/rtl/ttce_fifo.sv]
// Small synchronous queue of fixed-width words, power-of-two depth.
// Standalone; used for the command queue and the result queue.
module ttce_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int NW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == NW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? PW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? PW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = NW'(cnt_r + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = NW'(cnt_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[hw/rtl/ttce_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Standalone; holds the screen cells.
module ttce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

[hw/rtl/ttce_front.sv]
// Front end: takes input words, classifies them into commands and queues them.
// Depends on ttce_pkg and ttce_fifo.
module ttce_front #(
  parameter int ROWS       = ttce_pkg::DEF_ROWS,
  parameter int COLUMNS    = ttce_pkg::DEF_COLUMNS,
  parameter int CMDQ_DEPTH = ttce_pkg::CMDQ_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  ttce_pkg::in_item_t in_data,
  output logic               cmd_valid,
  input  logic               cmd_pop,
  output ttce_pkg::cmd_t     cmd
);
  import ttce_pkg::*;

  cmd_t cmd_in;
  logic cmd_empty;

  always_comb begin
    cmd_in.char_code = in_data.char_code;
    cmd_in.read_row  = in_data.read_row;
    cmd_in.read_col  = in_data.read_col;
    cmd_in.read_ok   = (32'(in_data.read_row) < 32'(ROWS)) &&
                       (32'(in_data.read_col) < 32'(COLUMNS));
    case (in_data.operation)
      OP_PUT: begin
        case (in_data.char_code)
          CH_BACKSPACE: cmd_in.kind = CMD_BS;
          CH_TAB:       cmd_in.kind = CMD_TAB;
          CH_NEWLINE:   cmd_in.kind = CMD_NL;
          CH_RETURN:    cmd_in.kind = CMD_CR;
          default:      cmd_in.kind = CMD_PUT;
        endcase
      end
      OP_CLEAR: cmd_in.kind = CMD_CLEAR;
      OP_READ:  cmd_in.kind = CMD_READ;
      default:  cmd_in.kind = CMD_NOP;
    endcase
  end

  ttce_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMDQ_DEPTH)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd),
    .empty (cmd_empty)
  );

  assign cmd_valid = !cmd_empty;

endmodule

[hw/rtl/ttce_back.sv]
// Back end: runs queued commands against the cursor, the row pointer and the
// screen RAM, and sweeps rows for scroll and clear. Depends on ttce_pkg, ttce_ram.
module ttce_back #(
  parameter int ROWS    = ttce_pkg::DEF_ROWS,
  parameter int COLUMNS = ttce_pkg::DEF_COLUMNS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  input  logic                cmd_valid,
  output logic                cmd_pop,
  input  ttce_pkg::cmd_t      cmd,
  input  logic                res_full,
  output logic                res_push,
  output ttce_pkg::out_item_t res_data
);
  import ttce_pkg::*;

  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = $clog2(COLUMNS);
  localparam int AW    = RW + CW;
  localparam int DEPTH = ROWS * (2 ** CW);

  back_state_t   state_r, state_nxt;
  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [RW-1:0] top_r, top_nxt;
  logic [RW-1:0] sw_row_r, sw_row_nxt;
  logic [CW-1:0] sw_col_r, sw_col_nxt;
  logic [7:0]    color_r;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;
  logic [15:0]   res_cell;

  logic [CW:0]   col_inc, tab_col;
  logic [RW-1:0] phys_cur;
  logic [RW:0]   top_inc;
  logic [15:0]   blank;

  // Map a screen row onto a RAM row through the scroll pointer.
  function automatic logic [RW-1:0] phys_row(input logic [RW-1:0] r,
                                             input logic [RW-1:0] top);
    logic [RW:0] s;
    s = {1'b0, r} + {1'b0, top};
    if (s >= (RW+1)'(ROWS)) begin
      s = s - (RW+1)'(ROWS);
    end
    return s[RW-1:0];
  endfunction

  assign blank    = {color_r, CH_SPACE};
  assign phys_cur = phys_row(cur_row_r, top_r);
  assign col_inc  = {1'b0, cur_col_r} + (CW+1)'(1);
  assign tab_col  = ({1'b0, cur_col_r} + (CW+1)'(4)) & ~(CW+1)'(3);
  assign top_inc  = {1'b0, top_r} + (RW+1)'(1);

  always_comb begin
    logic adv;
    adv         = 1'b0;
    state_nxt   = state_r;
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    top_nxt     = top_r;
    sw_row_nxt  = sw_row_r;
    sw_col_nxt  = sw_col_r;
    cmd_pop     = 1'b0;
    res_push    = 1'b0;
    res_cell    = '0;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = blank;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    case (state_r)
      BK_IDLE: begin
        if (cmd_valid && !res_full) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            CMD_PUT: begin
              ram_we    = 1'b1;
              ram_waddr = {phys_cur, cur_col_r};
              ram_wdata = {color_r, cmd.char_code};
              if (col_inc >= (CW+1)'(COLUMNS)) begin
                cur_col_nxt = '0;
                adv         = 1'b1;
              end else begin
                cur_col_nxt = col_inc[CW-1:0];
              end
            end
            CMD_BS: begin
              if (cur_col_r != '0) begin
                cur_col_nxt = CW'(cur_col_r - 1'b1);
                ram_we      = 1'b1;
                ram_waddr   = {phys_cur, cur_col_nxt};
              end
            end
            CMD_TAB: begin
              if (tab_col >= (CW+1)'(COLUMNS)) begin
                cur_col_nxt = '0;
                adv         = 1'b1;
              end else begin
                cur_col_nxt = tab_col[CW-1:0];
              end
            end
            CMD_NL: begin
              cur_col_nxt = '0;
              adv         = 1'b1;
            end
            CMD_CR: cur_col_nxt = '0;
            CMD_CLEAR: begin
              cur_row_nxt = '0;
              cur_col_nxt = '0;
              top_nxt     = '0;
              sw_row_nxt  = '0;
              sw_col_nxt  = '0;
              state_nxt   = BK_CLEAR;
            end
            CMD_READ: begin
              if (cmd.read_ok) begin
                ram_re    = 1'b1;
                ram_raddr = {phys_row(RW'(cmd.read_row), top_r), CW'(cmd.read_col)};
                state_nxt = BK_READ;
              end
            end
            default: ;
          endcase
          if (adv) begin
            if (cur_row_r == RW'(ROWS - 1)) begin
              // advance the pointer; the old top row becomes the blank bottom row
              top_nxt    = (top_inc == (RW+1)'(ROWS)) ? '0 : top_inc[RW-1:0];
              sw_row_nxt = top_r;
              sw_col_nxt = '0;
              state_nxt  = BK_SCROLL;
            end else begin
              cur_row_nxt = RW'(cur_row_r + 1'b1);
            end
          end
          res_push = (state_nxt == BK_IDLE);
        end
      end
      BK_READ: begin
        res_cell  = ram_rdata;
        res_push  = 1'b1;
        state_nxt = BK_IDLE;
      end
      BK_SCROLL: begin
        ram_we    = 1'b1;
        ram_waddr = {sw_row_r, sw_col_r};
        if (sw_col_r == CW'(COLUMNS - 1)) begin
          res_push  = 1'b1;
          state_nxt = BK_IDLE;
        end else begin
          sw_col_nxt = CW'(sw_col_r + 1'b1);
        end
      end
      BK_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = {sw_row_r, sw_col_r};
        if (sw_col_r == CW'(COLUMNS - 1)) begin
          sw_col_nxt = '0;
          if (sw_row_r == RW'(ROWS - 1)) begin
            res_push  = 1'b1;
            state_nxt = BK_IDLE;
          end else begin
            sw_row_nxt = RW'(sw_row_r + 1'b1);
          end
        end else begin
          sw_col_nxt = CW'(sw_col_r + 1'b1);
        end
      end
      default: state_nxt = BK_IDLE;
    endcase

    res_data.cell_value = res_cell;
    res_data.cursor_row = 5'(cur_row_nxt);
    res_data.cursor_col = 7'(cur_col_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      cur_row_r <= '0;
      cur_col_r <= '0;
      top_r     <= '0;
      sw_row_r  <= '0;
      sw_col_r  <= '0;
      color_r   <= TEXT_COLOR_RST;
    end else begin
      state_r   <= state_nxt;
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      top_r     <= top_nxt;
      sw_row_r  <= sw_row_nxt;
      sw_col_r  <= sw_col_nxt;
      if (cfg_we) begin
        color_r <= cfg_wdata;
      end
    end
  end

  ttce_ram #(
    .WIDTH(16),
    .DEPTH(DEPTH)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

[hw/rtl/text_terminal_char_engine.sv]
// Text terminal character engine. Put, backspace, tab, newline, return, the unused op
// and out-of-range reads finish in the back end's idle state; an in-range read adds a
// registered RAM read, a bottom-row scroll a one-row sweep, clear a full-screen sweep.
// The back end retires one simple command per cycle while the result queue has room;
// sweeps hold it one cell a cycle. Synchronous active-low reset empties both queues,
// homes the cursor and sets the color to 10; screen RAM holds garbage until a clear or write.
module text_terminal_char_engine #(
  parameter int ROWS    = ttce_pkg::DEF_ROWS,
  parameter int COLUMNS = ttce_pkg::DEF_COLUMNS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  ttce_pkg::in_item_t  in_data,
  output logic                empty,
  input  logic                pop,
  output ttce_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);
  import ttce_pkg::*;

  cmd_t      cmd;
  logic      cmd_valid, cmd_pop;
  logic      res_full, res_push;
  out_item_t res_data;

  ttce_front #(
    .ROWS      (ROWS),
    .COLUMNS   (COLUMNS),
    .CMDQ_DEPTH(CMDQ_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  ttce_back #(
    .ROWS   (ROWS),
    .COLUMNS(COLUMNS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  ttce_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(RESQ_DEPTH)
  ) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_data),
    .empty (empty)
  );

endmodule

[hw/rtl/ttce_checker.sv]
// Port-level checks for the text terminal character engine, bound to the top level.
// Depends on ttce_pkg.
module ttce_checker #(
  parameter int ROWS    = ttce_pkg::DEF_ROWS,
  parameter int COLUMNS = ttce_pkg::DEF_COLUMNS
) (
  input logic                clk,
  input logic                rst_n,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input ttce_pkg::out_item_t out_data
);
  import ttce_pkg::*;

  // hold the waiting word until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_data))
    else $error("result word changed or vanished while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (ROWS > 32) || (32'(out_data.cursor_row) < 32'(ROWS)))
    else $error("cursor row beyond last row");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (COLUMNS > 128) || (32'(out_data.cursor_col) < 32'(COLUMNS)))
    else $error("cursor column beyond last column");

endmodule

bind text_terminal_char_engine ttce_checker #(
  .ROWS   (ROWS),
  .COLUMNS(COLUMNS)
) u_ttce_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .out_data (out_data)
);
